>>> rtl/core/ipid_pkg.sv
package ipid_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX     = 3'd5;

    localparam logic ACTION_COMPUTE  = 1'b0;
    localparam logic ACTION_ACTIVATE = 1'b1;

    // values inside the block are scaled by 1000
    localparam logic signed [25:0] SCALE       = 26'sd1000;
    localparam logic [11:0]        DERIV_MULT  = 12'd10;
    localparam logic signed [15:0] DEFAULT_MIN = 16'sd0;
    localparam logic signed [15:0] DEFAULT_MAX = 16'sd255;

    // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for x < 2**25
    localparam logic [25:0] RECIP_1000  = 26'd34359739;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic               action;
        logic [15:0]        measured;
        logic [15:0]        setpoint;
        logic signed [15:0] manual_output;
    } t_in;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               computed;
    } t_out;

    typedef struct packed {
        logic [7:0]         prop_gain;
        logic [7:0]         integ_gain;
        logic [7:0]         deriv_gain;
        logic               reverse_dir;
        logic signed [15:0] out_min;
        logic signed [15:0] out_max;
    } t_cfg;

    typedef enum logic [1:0] {
        K_NOP,
        K_ACT,
        K_RUN
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [25:0] p_term;
        logic signed [29:0] d_term;
        logic signed [25:0] ki_err;
        logic signed [25:0] seed;
    } t_cmd;

endpackage

>>> rtl/core/integer_pid_controller.sv
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   i_in  (action, measured, setpoint, manual_output)
// result    out        o_valid / i_ready   o_out (drive, computed)
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// one item per cycle while no result waits; items pass the queue, then stages 1 to 4
// the integrator add and clamp is a single register loop in the back end and sets the rate
// a two entry queue parts the front end from the back end; the back end pipeline halts
// as a whole while a result waits, and the input side stalls only once the queue is full
// synchronous active low reset: manual mode, integrator and last drive zero, out_max 255
module integer_pid_controller
    import ipid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in                   i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;
    logic w_push;
    logic w_full;
    logic w_queue_valid;
    logic w_pop;

    assign o_ready = !w_full;
    assign w_push  = i_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= '0;
            r_cfg.integ_gain  <= '0;
            r_cfg.deriv_gain  <= '0;
            r_cfg.reverse_dir <= 1'b0;
            r_cfg.out_min     <= DEFAULT_MIN;
            r_cfg.out_max     <= DEFAULT_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_data[7:0];
                CFG_INTEG_GAIN:  r_cfg.integ_gain  <= i_cfg_data[7:0];
                CFG_DERIV_GAIN:  r_cfg.deriv_gain  <= i_cfg_data[7:0];
                CFG_REVERSE_DIR: r_cfg.reverse_dir <= i_cfg_data[0];
                CFG_OUT_MIN:     r_cfg.out_min     <= $signed(i_cfg_data);
                CFG_OUT_MAX:     r_cfg.out_max     <= $signed(i_cfg_data);
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    ipid_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_push  (w_push),
        .i_in    (i_in),
        .o_cmd   (w_front_cmd)
    );

    ipid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_cmd   (w_queue_cmd)
    );

    ipid_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_queue_valid),
        .i_cmd       (w_queue_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out       (o_out)
    );

endmodule

>>> rtl/core/ipid_front.sv
module ipid_front
    import ipid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_push,
    input  t_in  i_in,
    output t_cmd o_cmd
);

    logic              r_active;
    logic [15:0]       r_prev_measured;
    logic              n_active;
    logic [15:0]       n_prev_measured;

    logic signed [16:0] w_err;
    logic signed [16:0] w_dmeas;
    logic signed [8:0]  w_kp;
    logic signed [8:0]  w_ki;
    logic [11:0]        w_kd_mag;
    logic signed [12:0] w_kd;
    t_kind              w_kind;

    always_comb begin
        w_err    = $signed({1'b0, i_in.setpoint}) - $signed({1'b0, i_in.measured});
        w_dmeas  = $signed({1'b0, i_in.measured}) - $signed({1'b0, r_prev_measured});
        w_kd_mag = 12'(i_cfg.deriv_gain) * DERIV_MULT;
        if (i_cfg.reverse_dir) begin
            w_kp = -$signed({1'b0, i_cfg.prop_gain});
            w_ki = -$signed({1'b0, i_cfg.integ_gain});
            w_kd = -$signed({1'b0, w_kd_mag});
        end else begin
            w_kp = $signed({1'b0, i_cfg.prop_gain});
            w_ki = $signed({1'b0, i_cfg.integ_gain});
            w_kd = $signed({1'b0, w_kd_mag});
        end

        w_kind          = K_NOP;
        n_active        = r_active;
        n_prev_measured = r_prev_measured;
        if (i_in.action == ACTION_ACTIVATE) begin
            if (!r_active) begin
                w_kind          = K_ACT;
                n_active        = 1'b1;
                n_prev_measured = i_in.measured;
            end
        end else if (r_active) begin
            w_kind          = K_RUN;
            n_prev_measured = i_in.measured;
        end

        o_cmd.kind   = w_kind;
        o_cmd.p_term = 26'(w_kp) * 26'(w_err);
        o_cmd.ki_err = 26'(w_ki) * 26'(w_err);
        o_cmd.d_term = 30'(w_kd) * 30'(w_dmeas);
        o_cmd.seed   = 26'(i_in.manual_output) * SCALE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active        <= 1'b0;
            r_prev_measured <= '0;
        end else if (i_push) begin
            r_active        <= n_active;
            r_prev_measured <= n_prev_measured;
        end
    end

endmodule

>>> rtl/core/ipid_queue.sv
module ipid_queue
    import ipid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_do_push;
    logic       w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_valid   = (r_count != 2'd0);
    assign o_cmd     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/ipid_back.sv
module ipid_back
    import ipid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_out
);

    logic               w_en;
    logic signed [25:0] w_lo;
    logic signed [25:0] w_hi;

    logic signed [25:0] r_integ;
    logic signed [25:0] n_integ;
    logic signed [26:0] w_integ_sum;
    logic signed [25:0] w_integ_run;
    logic signed [25:0] w_integ_seed;

    logic               r_s1_valid;
    logic               r_s1_computed;
    logic signed [30:0] r_s1_pd;
    logic signed [25:0] r_s1_integ;

    logic signed [31:0] w_sum;
    logic signed [25:0] w_sum_clamped;
    logic               r_s2_valid;
    logic               r_s2_computed;
    logic signed [25:0] r_s2_sum;

    logic [25:0]        w_neg_sum;
    logic [24:0]        w_mag;
    logic               r_s3_valid;
    logic               r_s3_computed;
    logic               r_s3_neg;
    logic [50:0]        r_s3_prod;

    logic [15:0]        w_quot;
    logic signed [15:0] w_drive;
    logic signed [15:0] r_last_drive;
    logic               r_o_valid;
    t_out               r_out;

    assign w_en    = !r_o_valid || i_ready;
    assign o_pop   = w_en;
    assign o_valid = r_o_valid;
    assign o_out   = r_out;

    // scaled limits, falling back to the default range when out_min is not below out_max
    always_comb begin
        if (i_cfg.out_min < i_cfg.out_max) begin
            w_lo = 26'(i_cfg.out_min) * SCALE;
            w_hi = 26'(i_cfg.out_max) * SCALE;
        end else begin
            w_lo = 26'(DEFAULT_MIN) * SCALE;
            w_hi = 26'(DEFAULT_MAX) * SCALE;
        end
    end

    // stage 1: integrator update
    always_comb begin
        w_integ_sum = 27'(r_integ) + 27'(i_cmd.ki_err);
        if (w_integ_sum < 27'(w_lo)) begin
            w_integ_run = w_lo;
        end else if (w_integ_sum > 27'(w_hi)) begin
            w_integ_run = w_hi;
        end else begin
            w_integ_run = 26'(w_integ_sum);
        end

        if (i_cmd.seed < w_lo) begin
            w_integ_seed = w_lo;
        end else if (i_cmd.seed > w_hi) begin
            w_integ_seed = w_hi;
        end else begin
            w_integ_seed = i_cmd.seed;
        end

        case (i_cmd.kind)
            K_RUN:   n_integ = w_integ_run;
            K_ACT:   n_integ = w_integ_seed;
            default: n_integ = r_integ;
        endcase
    end

    // stage 2: output sum and clamp
    always_comb begin
        w_sum = 32'(r_s1_pd) + 32'(r_s1_integ);
        if (w_sum < 32'(w_lo)) begin
            w_sum_clamped = w_lo;
        end else if (w_sum > 32'(w_hi)) begin
            w_sum_clamped = w_hi;
        end else begin
            w_sum_clamped = 26'(w_sum);
        end
    end

    // stage 3: magnitude times reciprocal of the scale
    always_comb begin
        w_neg_sum = 26'(-r_s2_sum);
        w_mag     = r_s2_sum[25] ? w_neg_sum[24:0] : r_s2_sum[24:0];
    end

    // stage 4: quotient truncated toward zero
    always_comb begin
        w_quot = r_s3_prod[RECIP_SHIFT +: 16];
        if (r_s3_neg) begin
            w_drive = $signed(16'(-w_quot));
        end else begin
            w_drive = $signed(w_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pd       <= 31'(i_cmd.p_term) - 31'(i_cmd.d_term);
            r_s1_integ    <= n_integ;
            r_s1_computed <= (i_cmd.kind == K_RUN);
            r_s2_sum      <= w_sum_clamped;
            r_s2_computed <= r_s1_computed;
            r_s3_prod     <= 51'(w_mag) * 51'(RECIP_1000);
            r_s3_neg      <= r_s2_sum[25];
            r_s3_computed <= r_s2_computed;
            if (r_s3_valid) begin
                r_out.computed <= r_s3_computed;
                r_out.drive    <= r_s3_computed ? w_drive : r_last_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ      <= '0;
            r_last_drive <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else if (w_en) begin
            if (i_cmd_valid) begin
                r_integ <= n_integ;
            end
            if (r_s3_valid && r_s3_computed) begin
                r_last_drive <= w_drive;
            end
            r_s1_valid <= i_cmd_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_o_valid  <= r_s3_valid;
        end
    end

endmodule
